### sv/ist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;

	localparam int MAX_INTERVALS = 16;
	localparam int COORD_BITS    = 32;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int IDX_W         = $clog2(MAX_INTERVALS);

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]            op;
		logic [COORD_BITS-1:0] range_start;
		logic [COORD_BITS-1:0] range_end;
	} in_t;

	typedef struct packed {
		logic       covered;
		logic [1:0] status;
		logic [4:0] interval_count;
	} out_t;

endpackage
`default_nettype wire

### sv/interval_set_tracker.sv
// channel | signals                        | transfer when
// --------+--------------------------------+----------------------
// in      | in_valid, in_ready, in_data    | in_valid & in_ready
// out     | out_valid, out_ready, out_data | out_valid & out_ready
//
// One item at a time; in_ready is high only while the sequencer is idle.
// An item is accepted, the interval memories (one read port each) are scanned,
// the plan is made, the tail is shifted, up to 2 writes place new entries,
// the count is committed, and the result is posted. Invalid items go straight
// to posting, queries after the scan, and overflowing or no-op items after the plan.
// Reset clears the count; memory contents need no clearing.
// The output register holds a result while out_ready is low; the next item
// is taken meanwhile and waits in the post state only if still blocked.
`timescale 1ns / 1ps
`default_nettype none
module interval_set_tracker import ist_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_CALC = 6'b000100,
		S_COPY = 6'b001000,
		S_NEW  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [COORD_BITS-1:0] starts_mem [MAX_INTERVALS];
	logic [COORD_BITS-1:0] ends_mem   [MAX_INTERVALS];
	logic [COORD_BITS-1:0] rd_start_q, rd_end_q;
	logic [IDX_W-1:0]      mem_ra, mem_wa;
	logic                  mem_wen;
	logic [COORD_BITS-1:0] mem_wstart, mem_wend;

	logic [1:0]            op_q;
	logic [COORD_BITS-1:0] a_q, b_q;
	logic [CNT_W-1:0]      count_q, sc_q, i_q, j_q, rp_q, left_q, dofs_q, newcnt_q;
	logic                  got_i_q, cov_q, up_q;
	logic [COORD_BITS-1:0] s_i_q, e_last_q;
	logic [COORD_BITS-1:0] ns0_q, ne0_q, ns1_q, ne1_q;
	logic [1:0]            n_q, wk_q;
	logic                  rd_v_s1, cp_v_s1;
	logic [IDX_W-1:0]      cp_wa_s1;
	logic [1:0]            res_st_q;
	logic                  out_valid_q;
	out_t                  out_q;

	// scan predicates and plan
	logic                  is_add, pi, pj, hit;
	logic [CNT_W-1:0]      jj;
	logic                  cut_lo, cut_hi;
	logic [1:0]            n_c;
	logic [COORD_BITS-1:0] ns0_c, ne0_c;
	logic [CNT_W:0]        newcnt_c;
	logic                  bad_in;

	assign is_add = (op_q == OP_ADD);
	assign pi  = is_add ? (rd_end_q < a_q) : (rd_end_q <= a_q);
	assign pj  = is_add ? (rd_start_q <= b_q) : (rd_start_q < b_q);
	assign hit = (rd_start_q <= a_q) && (rd_end_q >= b_q);
	assign bad_in = (in_data.op == OP_RESERVED) ||
		(in_data.range_start >= in_data.range_end);

	always_comb begin
		cut_lo = s_i_q < a_q;
		cut_hi = e_last_q > b_q;
		if (is_add) begin
			jj    = (j_q > i_q) ? j_q : i_q;
			n_c   = 2'd1;
			ns0_c = (j_q > i_q && s_i_q < a_q) ? s_i_q : a_q;
			ne0_c = (j_q > i_q && e_last_q > b_q) ? e_last_q : b_q;
		end else begin
			jj    = j_q;
			n_c   = {1'b0, cut_lo} + {1'b0, cut_hi};
			ns0_c = cut_lo ? s_i_q : b_q;
			ne0_c = cut_lo ? a_q : e_last_q;
		end
		newcnt_c = {1'b0, count_q} - {1'b0, jj - i_q} + (CNT_W+1)'(n_c);
	end

	always_comb begin
		mem_ra = (state_q == S_SCAN) ? sc_q[IDX_W-1:0] : rp_q[IDX_W-1:0];
		mem_wen    = 1'b0;
		mem_wa     = cp_wa_s1;
		mem_wstart = rd_start_q;
		mem_wend   = rd_end_q;
		if (cp_v_s1) begin
			mem_wen = 1'b1;
		end else if (state_q == S_NEW && wk_q != n_q) begin
			mem_wen    = 1'b1;
			mem_wa     = IDX_W'(i_q + CNT_W'(wk_q));
			mem_wstart = (wk_q == 2'd0) ? ns0_q : ns1_q;
			mem_wend   = (wk_q == 2'd0) ? ne0_q : ne1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wen) begin
			starts_mem[mem_wa] <= mem_wstart;
			ends_mem[mem_wa]   <= mem_wend;
		end
		rd_start_q <= starts_mem[mem_ra];
		rd_end_q   <= ends_mem[mem_ra];
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_v_s1     <= 1'b0;
			cp_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			op_q <= '0; a_q <= '0; b_q <= '0;
			sc_q <= '0; i_q <= '0; j_q <= '0; rp_q <= '0; left_q <= '0;
			dofs_q <= '0; newcnt_q <= '0; got_i_q <= 1'b0; cov_q <= 1'b0;
			up_q <= 1'b0; s_i_q <= '0; e_last_q <= '0;
			ns0_q <= '0; ne0_q <= '0; ns1_q <= '0; ne1_q <= '0;
			n_q <= '0; wk_q <= '0; cp_wa_s1 <= '0; res_st_q <= ST_OK;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN) && (sc_q < count_q);
			cp_v_s1 <= (state_q == S_COPY) && (left_q != '0);
			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_data.op;
						a_q      <= in_data.range_start;
						b_q      <= in_data.range_end;
						sc_q     <= '0;
						i_q      <= '0;
						j_q      <= '0;
						got_i_q  <= 1'b0;
						cov_q    <= 1'b0;
						res_st_q <= bad_in ? ST_INVALID : ST_OK;
						state_q  <= bad_in ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (sc_q < count_q)
						sc_q <= sc_q + 1'b1;
					if (rd_v_s1) begin
						if (pi) begin
							i_q <= i_q + 1'b1;
						end else if (!got_i_q) begin
							got_i_q <= 1'b1;
							s_i_q   <= rd_start_q;
						end
						if (pj) begin
							j_q      <= j_q + 1'b1;
							e_last_q <= rd_end_q;
						end
						if (hit)
							cov_q <= 1'b1;
					end
					if (sc_q == count_q && !rd_v_s1)
						state_q <= (op_q == OP_QUERY) ? S_DONE : S_CALC;
				end
				S_CALC: begin
					j_q      <= jj;
					n_q      <= n_c;
					ns0_q    <= ns0_c;
					ne0_q    <= ne0_c;
					ns1_q    <= b_q;
					ne1_q    <= e_last_q;
					newcnt_q <= newcnt_c[CNT_W-1:0];
					dofs_q   <= CNT_W'(n_c) + i_q - jj;
					up_q     <= CNT_W'(n_c) > (jj - i_q);
					rp_q     <= (CNT_W'(n_c) > (jj - i_q)) ? count_q - 1'b1 : jj;
					left_q   <= count_q - jj;
					wk_q     <= '0;
					cov_q    <= 1'b0;
					if (!is_add && j_q <= i_q) begin
						state_q <= S_DONE;
					end else if (newcnt_c > (CNT_W+1)'(MAX_INTERVALS)) begin
						res_st_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					// shift the tail; walk down when growing so no entry is overwritten first
					if (left_q != '0) begin
						cp_wa_s1 <= IDX_W'(rp_q + dofs_q);
						rp_q     <= up_q ? rp_q - 1'b1 : rp_q + 1'b1;
						left_q   <= left_q - 1'b1;
					end else if (!cp_v_s1) begin
						state_q <= S_NEW;
					end
				end
				S_NEW: begin
					if (wk_q != n_q) begin
						wk_q <= wk_q + 1'b1;
					end else begin
						count_q <= newcnt_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.covered        <= cov_q && (res_st_q == ST_OK);
						out_q.status         <= res_st_q;
						out_q.interval_count <= 5'(count_q);
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/ist_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ist_checker import ist_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire in_t  in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_cov_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.covered |-> out_data.status == ST_OK)
		else $error("covered set on a rejected item");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.interval_count <= 5'(MAX_INTERVALS))
		else $error("interval count beyond table size");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == ST_OK || out_data.status == ST_FULL ||
			out_data.status == ST_INVALID)
		else $error("unknown status code");

endmodule

bind interval_set_tracker ist_checker u_ist_checker (.*);
`default_nettype wire

### verif/ist_checker.sv
`timescale 1ns / 1ps
module ist_scoreboard import ist_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  wire in_t  in_data,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire out_t out_data,
	output int        fail_count,
	output int        pending
);

	logic [COORD_BITS-1:0] lo_tab [MAX_INTERVALS];
	logic [COORD_BITS-1:0] hi_tab [MAX_INTERVALS];
	int                    n_ivl;
	out_t                  result_q [$];

	assign pending = result_q.size();

	// Replace entries [a,b) with up to two new entries, if the result fits.
	function automatic bit splice_tab(int a, int b, int n,
			logic [COORD_BITS-1:0] s0, logic [COORD_BITS-1:0] e0,
			logic [COORD_BITS-1:0] s1, logic [COORD_BITS-1:0] e1);
		logic [COORD_BITS-1:0] ts [$];
		logic [COORD_BITS-1:0] te [$];
		int                    nc;
		nc = n_ivl - (b - a) + n;
		if (nc > MAX_INTERVALS)
			return 0;
		for (int r = 0; r < a; r++) begin
			ts.push_back(lo_tab[r]);
			te.push_back(hi_tab[r]);
		end
		if (n > 0) begin
			ts.push_back(s0);
			te.push_back(e0);
		end
		if (n > 1) begin
			ts.push_back(s1);
			te.push_back(e1);
		end
		for (int r = b; r < n_ivl; r++) begin
			ts.push_back(lo_tab[r]);
			te.push_back(hi_tab[r]);
		end
		for (int r = 0; r < nc; r++) begin
			lo_tab[r] = ts[r];
			hi_tab[r] = te[r];
		end
		n_ivl = nc;
		return 1;
	endfunction

	function automatic out_t apply_op(in_t it);
		out_t                  res;
		logic [COORD_BITS-1:0] a, b, ns[2], ne[2];
		int                    i, j, n;
		a = it.range_start;
		b = it.range_end;
		res = '0;
		i = 0;
		j = 0;
		n = 0;
		if (a >= b || !(it.op inside {OP_ADD, OP_REMOVE, OP_QUERY})) begin
			res.status = ST_INVALID;
		end else if (it.op == OP_ADD) begin
			while (i < n_ivl && hi_tab[i] < a) i++;
			while (j < n_ivl && lo_tab[j] <= b) j++;
			ns[0] = a;
			ne[0] = b;
			if (j > i) begin
				if (lo_tab[i] < a) ns[0] = lo_tab[i];
				if (hi_tab[j-1] > b) ne[0] = hi_tab[j-1];
			end else begin
				j = i;
			end
			res.status = splice_tab(i, j, 1, ns[0], ne[0], '0, '0) ? ST_OK : ST_FULL;
		end else if (it.op == OP_REMOVE) begin
			while (i < n_ivl && hi_tab[i] <= a) i++;
			while (j < n_ivl && lo_tab[j] < b) j++;
			res.status = ST_OK;
			if (j > i) begin
				if (lo_tab[i] < a) begin
					ns[n] = lo_tab[i];
					ne[n] = a;
					n++;
				end
				if (hi_tab[j-1] > b) begin
					ns[n] = b;
					ne[n] = hi_tab[j-1];
					n++;
				end
				res.status = splice_tab(i, j, n, ns[0], ne[0], ns[1], ne[1])
					? ST_OK : ST_FULL;
			end
		end else begin
			res.status = ST_OK;
			for (int k = 0; k < n_ivl; k++)
				if (lo_tab[k] <= a && hi_tab[k] >= b)
					res.covered = 1'b1;
		end
		res.interval_count = 5'(n_ivl);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_ivl = 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					out_t exp_r;
					exp_r = result_q.pop_front();
					if (out_data !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("expected cov=%0b st=%0d cnt=%0d got cov=%0b st=%0d cnt=%0d",
								exp_r.covered, exp_r.status, exp_r.interval_count,
								out_data.covered, out_data.status, out_data.interval_count);
					end
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(apply_op(in_data));
		end
	end

endmodule

### verif/tb_interval_set_tracker.sv
`timescale 1ns / 1ps
module tb_interval_set_tracker;
	import ist_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	int   fail_count;
	int   pending;
	int   cycle_cnt;
	bit   calm;

	interval_set_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	ist_scoreboard i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > 400000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 24);
	end

	// Idle at random, then hold valid until the transfer.
	task automatic send_item(logic [1:0] op, logic [31:0] s, logic [31:0] e);
		while (!calm && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{op: op, range_start: s, range_end: e};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
			2: return $urandom_range(0, 3);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	initial begin
		logic [31:0] s, e;
		logic [1:0]  op;
		int          r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send_item(OP_QUERY, 0, 1);
		send_item(OP_REMOVE, 0, 32'hFFFF_FFFF);
		send_item(OP_ADD, 10, 20);
		send_item(OP_ADD, 20, 30);
		send_item(OP_ADD, 40, 50);
		send_item(OP_ADD, 5, 10);
		send_item(OP_QUERY, 5, 30);
		send_item(OP_QUERY, 5, 31);
		send_item(OP_REMOVE, 12, 14);
		send_item(OP_REMOVE, 60, 70);
		send_item(OP_ADD, 7, 7);
		send_item(OP_ADD, 9, 3);
		send_item(OP_RESERVED, 1, 2);
		send_item(OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		for (int k = 0; k < 18; k++)
			send_item(OP_ADD, 100 + 4 * k, 102 + 4 * k);
		send_item(OP_REMOVE, 0, 32'hFFFF_FFFF);
		// random, with a calm stretch in the middle
		for (int k = 0; k < 450; k++) begin
			calm = (k >= 200 && k < 260);
			r = $urandom_range(0, 99);
			op = (r < 45) ? OP_ADD : (r < 75) ? OP_REMOVE : (r < 97) ? OP_QUERY : OP_RESERVED;
			s = pick_coord();
			if ($urandom_range(0, 9) == 0)
				e = pick_coord();
			else
				e = s + $urandom_range(1, 40);
			if (e <= s && $urandom_range(0, 3) != 0)
				e = 32'hFFFF_FFFF;
			send_item(op, s, e);
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
